// File: src/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types and constants for the Hall sensor homing sequencer.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned THRESH_W       = 10;
  localparam int unsigned MIN_OUT_W      = 16;
  localparam int unsigned SAMPLE_W       = 10;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [THRESH_W-1:0]  RESET_THRESHOLD   = THRESH_W'(100);
  localparam logic [MIN_OUT_W-1:0] RESET_MIN_OUTSIDE = MIN_OUT_W'(20);

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_THRESHOLD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OUTSIDE_STEPS = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FIND    = 3'd1,
    PH_LEAVE   = 3'd2,
    PH_INFIELD = 3'd3,
    PH_CENTER  = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_FWD  = 2'd1,
    CMD_BACK = 2'd2,
    CMD_ZERO = 2'd3
  } cmd_t;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

endpackage

// File: src/hall_sensor_homing_sequencer.sv
// ----------------------------------------------------------------------------
// hall_sensor_homing_sequencer
// Homing sequencer for a stepper pointer with a Hall sensor: finds the
// magnet, crosses its field while counting, steps back half and zeroes.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_func, in_sensor_sample
//   out      output     out_valid / out_stall out_step_command, out_done_res,
//                                             out_phase
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low: an item is captured
// in the input register, then the phase and counter update and the result
// register loads once the output is empty or not stalled, setting out_valid.
// The input register takes one more item while a result waits at the output.
// Synchronous active-low reset returns the phase to idle, clears the counter
// and restores both configuration registers to their defaults.
// ----------------------------------------------------------------------------
module hall_sensor_homing_sequencer
  import hss_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [SAMPLE_W-1:0]   in_sensor_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_step_command,
  output logic                  out_done_res,
  output logic [2:0]            out_phase,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned WIDE_W =
    ((COUNT_BITS > MIN_OUT_W) ? COUNT_BITS : MIN_OUT_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [THRESH_W-1:0]   thresh_r;
  logic [MIN_OUT_W-1:0]  min_out_r;

  logic                  in_valid_r;
  logic                  func_r;
  logic [SAMPLE_W-1:0]   sample_r;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic                  out_valid_r;
  cmd_t                  cmd_r, cmd_nxt;
  logic                  done_r, done_nxt;
  phase_t                ophase_r;

  logic                  advance;
  logic                  present;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] min_load;
  logic                  count_le_min;
  logic [WIDE_W-1:0]     count_wide;
  logic [WIDE_W-1:0]     min_wide;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;

  assign present      = sample_r < thresh_r;
  assign count_wide   = WIDE_W'(count_r);
  assign min_wide     = WIDE_W'(min_out_r);
  assign count_le_min = count_wide <= min_wide;
  assign count_inc    = (count_r == CNT_MAX) ? CNT_MAX : count_r + 1'b1;
  assign min_load     = (min_wide >= WIDE_W'(CNT_MAX)) ? CNT_MAX
                                                       : COUNT_BITS'(min_wide + 1'b1);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    if (func_r == FUNC_START) begin
      phase_nxt = PH_FIND;
      count_nxt = '0;
    end else begin
      case (phase_r)
        PH_FIND: begin
          if (present && count_le_min) begin
            count_nxt = min_load;
            phase_nxt = PH_LEAVE;
          end else if (present) begin
            count_nxt = '0;
            phase_nxt = PH_INFIELD;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_LEAVE: begin
          if (count_r == '0) begin
            phase_nxt = PH_FIND;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        PH_INFIELD: begin
          if (!present) begin
            phase_nxt = PH_CENTER;
            count_nxt = count_r >> 1;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_CENTER: begin
          if (count_r == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cmd_nxt  = CMD_NONE;
    done_nxt = 1'b0;
    if (func_r == FUNC_TICK) begin
      case (phase_r)
        PH_FIND: begin
          if (!present) begin
            cmd_nxt = CMD_FWD;
          end
        end
        PH_LEAVE: begin
          if (count_r != '0) begin
            cmd_nxt = CMD_BACK;
          end
        end
        PH_INFIELD: begin
          if (present) begin
            cmd_nxt = CMD_FWD;
          end
        end
        PH_CENTER: begin
          cmd_nxt = (count_r == '0) ? CMD_ZERO : CMD_BACK;
        end
        PH_DONE: begin
          done_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= RESET_THRESHOLD;
      min_out_r <= RESET_MIN_OUTSIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIELD_THRESHOLD:   thresh_r  <= cfg_wdata[THRESH_W-1:0];
        CFG_MIN_OUTSIDE_STEPS: min_out_r <= cfg_wdata[MIN_OUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r   <= in_func;
      sample_r <= in_sensor_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_r    <= cmd_nxt;
      done_r   <= done_nxt;
      ophase_r <= phase_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_command = cmd_r;
  assign out_done_res     = done_r;
  assign out_phase        = ophase_r;

  a_done_in_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (ophase_r == PH_DONE))
    else $error("done reported outside the calibrated phase");

  a_zero_enters_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && cmd_r == CMD_ZERO) |-> (ophase_r == PH_DONE))
    else $error("zero command without entering the calibrated phase");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_state_holds_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(phase_r) && $stable(count_r)))
    else $error("sequencer state changed without an item");

endmodule
